// ===== rtl/isl_pkg.sv =====
`timescale 1ns / 1ps
package isl_pkg;

  localparam int unsigned DepthDefault    = 256;
  localparam int unsigned PartWidthDefault = 32;
  localparam int unsigned CapacityReset   = 256;

  localparam int unsigned KIND_W = 3;
  localparam int unsigned STAT_W = 2;

  localparam logic [KIND_W-1:0] KIND_INSERT    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_APPEND    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_READ      = 3'd3;
  localparam logic [KIND_W-1:0] KIND_OVERWRITE = 3'd4;
  localparam logic [KIND_W-1:0] KIND_COMPARE   = 3'd5;
  localparam logic [KIND_W-1:0] KIND_CLEAR     = 3'd6;

  localparam logic [STAT_W-1:0] STAT_DONE = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OOR  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

  // broadcast to every cell in the execute cycle
  typedef struct packed {
    logic ins;  // open a gap at the target and load the new word there
    logic rem;  // close the gap at the target
    logic wr;   // load the new word at the target only
  } cell_ctrl_t;

endpackage

// ===== rtl/isl_cell.sv =====
`timescale 1ns / 1ps
module isl_cell import isl_pkg::*; #(
  parameter int unsigned DEPTH      = DepthDefault,
  parameter int unsigned PART_WIDTH = PartWidthDefault,
  parameter int unsigned IDX        = 0
) (
  input  logic                          clk_i,
  input  cell_ctrl_t                    ctrl_i,
  input  logic [$clog2(DEPTH+1)-1:0]    tgt_i,
  input  logic [$clog2(DEPTH+1)-1:0]    used_i,
  input  logic [2*PART_WIDTH-1:0]       new_i,
  input  logic [2*PART_WIDTH-1:0]       left_i,
  input  logic [2*PART_WIDTH-1:0]       right_i,
  output logic [2*PART_WIDTH-1:0]       data_o,
  output logic [2*PART_WIDTH-1:0]       hit_data_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W:0] MyIdx = (CNT_W + 1)'(IDX);

  logic [2*PART_WIDTH-1:0] data_q, data_d;
  logic [CNT_W:0]          tgt_x, used_x;
  logic                    at_tgt;

  assign tgt_x  = {1'b0, tgt_i};
  assign used_x = {1'b0, used_i};
  assign at_tgt = (MyIdx == tgt_x);

  always_comb begin
    data_d = data_q;
    if (ctrl_i.ins) begin
      if (at_tgt) begin
        data_d = new_i;
      end else if ((MyIdx > tgt_x) && (MyIdx <= used_x)) begin
        data_d = left_i;
      end
    end else if (ctrl_i.rem) begin
      if ((MyIdx >= tgt_x) && ((MyIdx + 1'b1) < used_x)) begin
        data_d = right_i;
      end
    end else if (ctrl_i.wr && at_tgt) begin
      data_d = new_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o     = data_q;
  assign hit_data_o = at_tgt ? data_q : '0;

endmodule

// ===== rtl/isl_or_tree.sv =====
`timescale 1ns / 1ps
module isl_or_tree import isl_pkg::*; #(
  parameter int unsigned DEPTH = DepthDefault,
  parameter int unsigned W     = 2 * PartWidthDefault
) (
  input  logic                      clk_i,
  input  logic [DEPTH-1:0][W-1:0]   leaf_i,
  output logic [W-1:0]              root_o
);

  localparam int unsigned LOG_D   = $clog2(DEPTH);
  localparam int unsigned GRP_LOG = (LOG_D + 1) / 2;
  localparam int unsigned GRP     = 1 << GRP_LOG;
  localparam int unsigned NGRP    = (DEPTH + GRP - 1) / GRP;

  logic [NGRP-1:0][W-1:0] grp_d, grp_q;

  always_comb begin
    grp_d = '0;
    for (int unsigned g = 0; g < NGRP; g++) begin
      for (int unsigned k = 0; k < GRP; k++) begin
        if (g * GRP + k < DEPTH) begin
          grp_d[g] = grp_d[g] | leaf_i[g * GRP + k];
        end
      end
    end
  end

  // first level of the tree is registered
  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
  end

  always_comb begin
    root_o = '0;
    for (int unsigned g = 0; g < NGRP; g++) begin
      root_o = root_o | grp_q[g];
    end
  end

endmodule

// ===== rtl/indexed_shift_list.sv =====
`timescale 1ns / 1ps
// a result is loaded once its request has passed the execute and done states and the output is free
// a new request is taken only in idle, after the last one has passed take, shift in the cell row and gather
// the read path is a two-level or-tree over the cells, its first level registered
// reset clears the entry count and sets capacity to 256 (limited to DEPTH)
// cell contents are not reset and hold nothing valid until written
module indexed_shift_list import isl_pkg::*; #(
  parameter int unsigned DEPTH      = DepthDefault,
  parameter int unsigned PART_WIDTH = PartWidthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [$clog2(DEPTH+1)-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [KIND_W-1:0]             kind_i,
  input  logic [$clog2(DEPTH+1)-1:0]    position_i,
  input  logic [PART_WIDTH-1:0]         real_part_i,
  input  logic [PART_WIDTH-1:0]         imag_part_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [STAT_W-1:0]             status_o,
  output logic [PART_WIDTH-1:0]         read_real_o,
  output logic [PART_WIDTH-1:0]         read_imag_o,
  output logic                          matches_res_o,
  output logic [$clog2(DEPTH+1)-1:0]    count_o,
  output logic                          is_empty_o,
  output logic                          is_full_o
);

  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned WORD_W = 2 * PART_WIDTH;
  localparam int unsigned CapRst = (CapacityReset > DEPTH) ? DEPTH : CapacityReset;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [CNT_W-1:0]  cap_q;
  logic [CNT_W-1:0]  used_q, used_d;
  logic [CNT_W-1:0]  cap_eff;
  logic              full;

  logic [KIND_W-1:0] kind_q;
  logic [CNT_W-1:0]  tgt_q;
  logic [WORD_W-1:0] new_q;
  logic [STAT_W-1:0] stat_q, stat_d;

  cell_ctrl_t        ctrl;
  logic              in_acc, out_free;

  logic [DEPTH-1:0][WORD_W-1:0] cell_data, cell_hit;
  logic [WORD_W-1:0]            rd_word;

  logic              out_valid_q;
  logic [STAT_W-1:0] status_q;
  logic [PART_WIDTH-1:0] rd_re_q, rd_im_q;
  logic              match_q;
  logic [CNT_W-1:0]  count_q;
  logic              empty_q, full_q;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign out_free    = ~out_valid_q | ~out_stall_i;

  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CNT_W'(1);
    end else if (cap_q > CNT_W'(DEPTH)) begin
      cap_eff = CNT_W'(DEPTH);
    end else begin
      cap_eff = cap_q;
    end
  end

  assign full = (used_q >= cap_eff);

  // decide the request against the count before it changes
  always_comb begin
    stat_d = STAT_DONE;
    ctrl   = '0;
    used_d = used_q;
    case (kind_q)
      KIND_INSERT: begin
        if (tgt_q > used_q) begin
          stat_d = STAT_OOR;
        end else if (full) begin
          stat_d = STAT_FULL;
        end else begin
          ctrl.ins = 1'b1;
          used_d   = used_q + 1'b1;
        end
      end
      KIND_APPEND: begin
        if (full) begin
          stat_d = STAT_FULL;
        end else begin
          ctrl.wr = 1'b1;
          used_d  = used_q + 1'b1;
        end
      end
      KIND_REMOVE: begin
        if (tgt_q >= used_q) begin
          stat_d = STAT_OOR;
        end else begin
          ctrl.rem = 1'b1;
          used_d   = used_q - 1'b1;
        end
      end
      KIND_READ, KIND_COMPARE: begin
        if (tgt_q >= used_q) begin
          stat_d = STAT_OOR;
        end
      end
      KIND_OVERWRITE: begin
        if (tgt_q >= used_q) begin
          stat_d = STAT_OOR;
        end else begin
          ctrl.wr = 1'b1;
        end
      end
      KIND_CLEAR: begin
        used_d = '0;
      end
      default: begin
      end
    endcase
    if (state_q != S_EXEC) begin
      ctrl   = '0;
      used_d = used_q;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cap_q       <= CNT_W'(CapRst);
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (~out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q <= kind_i;
      tgt_q  <= (kind_i == KIND_APPEND) ? used_q : position_i;
      new_q  <= {real_part_i, imag_part_i};
    end
    if (state_q == S_EXEC) begin
      stat_q <= stat_d;
    end
    if (state_q == S_DONE && out_free) begin
      status_q <= stat_q;
      if (kind_q == KIND_READ && stat_q == STAT_DONE) begin
        rd_re_q <= rd_word[WORD_W-1:PART_WIDTH];
        rd_im_q <= rd_word[PART_WIDTH-1:0];
      end else begin
        rd_re_q <= '0;
        rd_im_q <= '0;
      end
      match_q <= (kind_q == KIND_COMPARE) && (stat_q == STAT_DONE) && (rd_word == new_q);
      // length and flags travel with the word, the next request may change them
      count_q <= used_q;
      empty_q <= (used_q == '0);
      full_q  <= full;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = cell_data[i+1];
    end

    isl_cell #(
      .DEPTH      (DEPTH),
      .PART_WIDTH (PART_WIDTH),
      .IDX        (i)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .tgt_i      (tgt_q),
      .used_i     (used_q),
      .new_i      (new_q),
      .left_i     (left_w),
      .right_i    (right_w),
      .data_o     (cell_data[i]),
      .hit_data_o (cell_hit[i])
    );
  end

  // the first level samples the cells before the execute edge updates them
  isl_or_tree #(
    .DEPTH (DEPTH),
    .W     (WORD_W)
  ) u_tree (
    .clk_i  (clk_i),
    .leaf_i (cell_hit),
    .root_o (rd_word)
  );

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign read_real_o   = rd_re_q;
  assign read_imag_o   = rd_im_q;
  assign matches_res_o = match_q;
  assign count_o       = count_q;
  assign is_empty_o    = empty_q;
  assign is_full_o     = full_q;

endmodule
